// File: design/sop_pkg.sv
package sop_pkg;

  localparam int MAX_SPHERES = 1024;
  localparam int COORD_W     = 16;
  localparam int RAD_W       = 15;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

  // overlap arithmetic
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int RS_W   = RAD_W + 1;
  localparam int RS2_W  = 2 * RS_W;

  // stream and config port widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_CNT_W  = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_CHECK    = 1'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RAD_W-1:0]          r;
  } sop_entry_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } sop_test_stat_t;

endpackage

// File: design/sphere_overlap_placement_top.sv
// Sphere overlap placement: each input item is a candidate sphere centre
// (x, y, z, signed fixed point, LSB 1/256 length unit). The candidate is
// tested against every sphere already in the table; it overlaps when
// (sphere_radius + stored radius)^2 > dx^2 + dy^2 + dz^2, computed exactly.
// A candidate with no overlap is appended with the radius in force at that
// moment. With skip_overlap_check set, every candidate is appended while
// there is room. A full table drops the candidate and reports table_full.
// Exactly one result item per input item.
// Timing: one stored sphere is tested per cycle through the table's single
// read port feeding a three-stage overlap unit. A scanned item reads the
// stored spheres in turn, drains the pipe and then hands over its result;
// an overlap ends the reads early. Skip mode, an empty table or a full
// table go straight to handing over the result. The hand-over waits while
// the output register still holds an unread result. The next item is
// taken once the previous result has entered the output register.
// s_tready is high only between items; a finished result sits in the
// output register and does not block the next item.
// Config registers: index 0 sphere_radius, index 1 skip_overlap_check;
// write them only while the block is idle.
module sphere_overlap_placement_top (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: [15:0] cand_x, [31:16] cand_y, [47:32] cand_z
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sop_pkg::IN_DATA_W-1:0]    s_tdata,
  // tdata: [0] accepted, [1] overlap_found, [2] table_full,
  //        [13:3] placed_total, [15:14] zero
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sop_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [sop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sop_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sop_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t             state;
  sop_entry_t         cand;          // r unused: radius read live
  logic [CNT_W-1:0]   idx;           // next entry to read
  logic [CNT_W-1:0]   placed_count;
  logic               ovl;
  logic               full;
  logic [RAD_W-1:0]   sphere_radius;
  logic               skip_overlap_check;

  // table and overlap unit
  logic               rd_en;
  sop_entry_t         rd_entry;
  logic               rd_valid;
  logic               wr_en;
  sop_entry_t         wr_entry;
  sop_test_stat_t     stat;

  logic               out_free;
  logic               finish_go;
  logic               acc;
  logic               drained;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign finish_go = (state == S_FINISH) && out_free;
  assign acc       = !ovl && !full;
  assign wr_en     = finish_go && acc;
  assign rd_en     = (state == S_SCAN) && !ovl;
  assign drained   = !rd_valid && !stat.busy;

  always_comb begin
    wr_entry   = cand;
    wr_entry.r = sphere_radius;
  end

  sop_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (idx[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (placed_count[IDX_W-1:0]),
    .wr_entry (wr_entry)
  );

  sop_test u_test (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .entry    (rd_entry),
    .cand_x   (cand.x),
    .cand_y   (cand.y),
    .cand_z   (cand.z),
    .radius   (sphere_radius),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      idx                <= '0;
      placed_count       <= '0;
      ovl                <= 1'b0;
      full               <= 1'b0;
      sphere_radius      <= '0;
      skip_overlap_check <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPHERE_RADIUS: sphere_radius      <= cfg_data[RAD_W-1:0];
          REG_SKIP_CHECK:    skip_overlap_check <= cfg_data[0];
          default: ;
        endcase
      end

      // a result handed over on this edge keeps tvalid up
      if (m_tvalid && m_tready && !finish_go) begin
        m_tvalid <= 1'b0;
      end

      if (stat.hit) begin
        ovl <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cand.x <= s_tdata[COORD_W-1:0];
            cand.y <= s_tdata[16 +: COORD_W];
            cand.z <= s_tdata[32 +: COORD_W];
            cand.r <= '0;
            ovl    <= 1'b0;
            idx    <= '0;
            full   <= (placed_count == CNT_W'(MAX_SPHERES));
            // full, empty or skip mode: nothing to test
            if (placed_count == CNT_W'(MAX_SPHERES) || skip_overlap_check ||
                placed_count == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ovl || stat.hit || idx == placed_count - CNT_W'(1)) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (drained) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, OUT_CNT_W'(placed_count + CNT_W'(acc)), full, ovl, acc};
            if (acc) begin
              placed_count <= placed_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    placed_count <= CNT_W'(MAX_SPHERES))
    else $error("placed_count beyond table depth");

  // only written entries are read
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> idx < placed_count)
    else $error("read of unwritten entry");

  // no append while the overlap pipe still holds results
  a_write_drained: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (drained && placed_count < CNT_W'(MAX_SPHERES)))
    else $error("append with tests in flight or table full");

  // no new item while tests are in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || stat.busy) |-> !s_tready)
    else $error("input ready during scan");

  // a result is never both stored and overlapping or dropped
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[2:0]) == 1)
    else $error("inconsistent result flags");

endmodule

// File: design/sop_store.sv
module sop_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [sop_pkg::IDX_W-1:0] rd_addr,
  output sop_pkg::sop_entry_t      rd_entry,
  output logic                     rd_valid,
  input  logic                     wr_en,
  input  logic [sop_pkg::IDX_W-1:0] wr_addr,
  input  sop_pkg::sop_entry_t      wr_entry
);
  import sop_pkg::*;

  sop_entry_t mem [MAX_SPHERES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

// File: design/sop_test.sv
module sop_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  sop_pkg::sop_entry_t            entry,
  input  logic signed [sop_pkg::COORD_W-1:0] cand_x,
  input  logic signed [sop_pkg::COORD_W-1:0] cand_y,
  input  logic signed [sop_pkg::COORD_W-1:0] cand_z,
  input  logic [sop_pkg::RAD_W-1:0]      radius,
  output sop_pkg::sop_test_stat_t        stat
);
  import sop_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
  endfunction

  // stage 1: magnitudes of the differences, radius sum
  logic               v1;
  logic [COORD_W-1:0] dx, dy, dz;
  logic [RS_W-1:0]    rs;
  // stage 2: squares
  logic               v2;
  logic [SQ_W-1:0]    sx, sy, sz;
  logic [RS2_W-1:0]   rs2;
  // stage 3: compare
  logic               v3;
  logic               h3;

  logic [DIST_W-1:0]  d2;

  assign d2 = DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);

  always_ff @(posedge clk) begin
    dx  <= abs_diff(cand_x, entry.x);
    dy  <= abs_diff(cand_y, entry.y);
    dz  <= abs_diff(cand_z, entry.z);
    rs  <= RS_W'(radius) + RS_W'(entry.r);
    sx  <= SQ_W'(dx) * SQ_W'(dx);
    sy  <= SQ_W'(dy) * SQ_W'(dy);
    sz  <= SQ_W'(dz) * SQ_W'(dz);
    rs2 <= RS2_W'(rs) * RS2_W'(rs);
    h3  <= DIST_W'(rs2) > d2;   // touching is no overlap
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign stat.busy = v1 | v2 | v3;
  assign stat.hit  = v3 & h3;

endmodule
